### sv/utf8d_pkg.sv
// Package for the 31-bit UTF-8 stream decoder.
// Holds the decoder state type, lead byte prefix masks and field widths.
// No dependencies; used by utf8d_step and utf8_stream_decoder_31bit_core.
package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int LEN_W  = 3;

    // Lead byte prefix masks; a byte matches when (b & mask) == mask.
    localparam logic [7:0] LEAD6_MASK = 8'hFC;
    localparam logic [7:0] LEAD5_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_MASK = 8'hC0;

    // Payload bits kept from a lead byte, and from every following byte.
    localparam logic [7:0] KEEP6_MASK = 8'h01;
    localparam logic [7:0] KEEP5_MASK = 8'h03;
    localparam logic [7:0] KEEP4_MASK = 8'h07;
    localparam logic [7:0] KEEP3_MASK = 8'h0F;
    localparam logic [7:0] KEEP2_MASK = 8'h1F;
    localparam logic [7:0] KEEP1_MASK = 8'h7F;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [LEN_W-1:0] bytes_left;
        logic [CP_W-1:0]  accumulator;
        logic [LEN_W-1:0] open_length;
    } dec_state_t;

    // One decoded code point.
    typedef struct packed {
        logic             valid;
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
    } dec_result_t;

endpackage

### sv/utf8d_step.sv
// Per-byte decode step of the 31-bit UTF-8 stream decoder.
// Combinational: maps the current state and one byte to the next state and result.
// Depends on utf8d_pkg.
module utf8d_step (
    input  utf8d_pkg::dec_state_t           state,
    input  logic [utf8d_pkg::BYTE_W-1:0]    in_byte,
    output utf8d_pkg::dec_state_t           state_next,
    output utf8d_pkg::dec_result_t          result
);

    logic [utf8d_pkg::LEN_W-1:0]  lead_len;
    logic [7:0]                   lead_bits;
    logic [utf8d_pkg::CP_W-1:0]   acc_shifted;
    logic [utf8d_pkg::LEN_W-1:0]  left_dec;

    // Classify a lead byte by its leading ones, longest prefix first.
    always_comb begin
        if ((in_byte & utf8d_pkg::LEAD6_MASK) == utf8d_pkg::LEAD6_MASK) begin
            lead_len  = 3'd6;
            lead_bits = in_byte & utf8d_pkg::KEEP6_MASK;
        end else if ((in_byte & utf8d_pkg::LEAD5_MASK) == utf8d_pkg::LEAD5_MASK) begin
            lead_len  = 3'd5;
            lead_bits = in_byte & utf8d_pkg::KEEP5_MASK;
        end else if ((in_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_MASK) begin
            lead_len  = 3'd4;
            lead_bits = in_byte & utf8d_pkg::KEEP4_MASK;
        end else if ((in_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_MASK) begin
            lead_len  = 3'd3;
            lead_bits = in_byte & utf8d_pkg::KEEP3_MASK;
        end else if ((in_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_MASK) begin
            lead_len  = 3'd2;
            lead_bits = in_byte & utf8d_pkg::KEEP2_MASK;
        end else begin
            lead_len  = 3'd1;
            lead_bits = in_byte & utf8d_pkg::KEEP1_MASK;
        end
    end

    // A following byte shifts six more bits in; its top bits are ignored.
    assign acc_shifted = {state.accumulator[utf8d_pkg::CP_W-7:0],
                          in_byte[5:0] & utf8d_pkg::CONT_MASK[5:0]};
    assign left_dec    = state.bytes_left - 3'd1;

    // Next state and result for this byte.
    always_comb begin
        state_next        = state;
        result.valid      = 1'b0;
        result.code_point = '0;
        result.seq_length = '0;
        if (state.bytes_left == '0) begin
            if (lead_len == 3'd1) begin
                // Plain or stray byte: decoded at once.
                result.valid      = 1'b1;
                result.code_point = {{(utf8d_pkg::CP_W-8){1'b0}}, lead_bits};
                result.seq_length = 3'd1;
            end else begin
                // A lead opens a sequence.
                state_next.accumulator = {{(utf8d_pkg::CP_W-8){1'b0}}, lead_bits};
                state_next.open_length = lead_len;
                state_next.bytes_left  = lead_len - 3'd1;
            end
        end else if (left_dec == '0) begin
            // Final byte closes the sequence.
            result.valid            = 1'b1;
            result.code_point       = acc_shifted;
            result.seq_length       = state.open_length;
            state_next.bytes_left   = '0;
            state_next.accumulator  = '0;
            state_next.open_length  = '0;
        end else begin
            state_next.accumulator = acc_shifted;
            state_next.bytes_left  = left_dec;
        end
    end

endmodule

### sv/utf8_stream_decoder_31bit_core.sv
// Top level of the 31-bit UTF-8 stream decoder.
// Input register, per-byte decode step, result register with stream handshakes.
// Depends on utf8d_pkg and utf8d_step.

// Decodes a byte stream as UTF-8 in the original scheme of up to six bytes and
// 31 bits. One byte enters per s_ transfer; a code point leaves on the m_ side
// together with the number of bytes it used, at the final byte of its sequence.
// Bytes inside a sequence give no result, following bytes are not checked for
// the continuation form, and 0xFE/0xFF count as six-byte leads. The block takes
// one byte per clock unless m_tready stalls it: a byte is held in the input
// register, the decode step between that register and the result register is a
// single short pass, and the result register raises m_tvalid once the final byte
// of a sequence has passed through the decode step into it. Back pressure on
// m_tready stalls both registers; reset drops any open sequence.
module utf8_stream_decoder_31bit_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // [30:0] code_point, [33:31] seq_length, [39:34] zero
);

    logic                          in_valid_reg;
    logic [utf8d_pkg::BYTE_W-1:0]  in_byte_reg;
    utf8d_pkg::dec_state_t         state_reg;
    utf8d_pkg::dec_state_t         state_next;
    utf8d_pkg::dec_result_t        step_result;
    logic                          out_valid_reg;
    logic [utf8d_pkg::CP_W-1:0]    out_cp_reg;
    logic [utf8d_pkg::LEN_W-1:0]   out_len_reg;
    logic                          out_free;
    logic                          advance;

    // The result register can take a new value when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    utf8d_step u_step (
        .state      (state_reg),
        .in_byte    (in_byte_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    // Decoder state commits only when the byte moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && step_result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_result.valid) begin
            out_cp_reg  <= step_result.code_point;
            out_len_reg <= step_result.seq_length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_len_reg, out_cp_reg};

endmodule
